// ----- rtl/tma_pkg.sv -----
`default_nettype none
package tma_pkg;

    // Shared widths of the root and quotient pipes.
    localparam int RAD_W      = 64;
    localparam int ROOT_W     = 32;
    localparam int REM_W      = ROOT_W + 4;
    localparam int QUO_W      = 62;
    localparam int STEPS      = 2;
    localparam int SQ_STAGES  = ROOT_W / STEPS;
    localparam int DIV_STAGES = QUO_W / STEPS;
    localparam int SH_W       = 7;

    // Beat handed from the front end to the first root pipe.
    typedef struct packed {
        logic [RAD_W-1:0] rad;
        logic [RAD_W-1:0] qk;
        logic             deg;
    } mid_t;

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        logic [63:0] m;
        m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
        return m;
    endfunction

    function automatic logic signed [63:0] shr_sgn(input logic signed [63:0] v,
                                                   input logic [SH_W-1:0] s);
        logic [63:0] m;
        m = mag64(v) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    // Fewest right shifts that bring orall below 2^lim.
    function automatic logic [SH_W-1:0] norm_shift(input logic [63:0] orall,
                                                   input logic [SH_W-1:0] lim);
        logic [SH_W-1:0] m;
        int i;
        m = '0;
        for (i = 0; i < 64; i++) begin
            if (orall[i]) m = SH_W'(i);
        end
        return (m >= lim) ? SH_W'(m - lim + 1'b1) : '0;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/tma_front.sv -----
`default_nettype none
module tma_front #(
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          en,
    input  wire logic                          in_valid,
    input  wire logic signed [COORD_WIDTH-1:0] in_crd [12],
    output logic                               out_valid,
    output tma_pkg::mid_t                      out_mid
);
    import tma_pkg::*;

    localparam int DW  = COORD_WIDTH + 1;
    localparam int NST = 13;

    logic [NST-1:0] vld_reg;
    logic [NST-1:0] deg_reg;
    logic [NST-1:0] deg_next;

    logic signed [DW-1:0] p1_reg [4], q1_reg [4], p1_next [4], q1_next [4];
    logic signed [31:0]   p2_reg [4], q2_reg [4], p2_next [4], q2_next [4];
    logic signed [31:0]   p3_reg [4], p4_reg [4], p5_reg [4];
    logic signed [63:0]   m3_reg [6], m3_next [6];
    logic signed [63:0]   l4_reg, d4_reg, l4_next, d4_next;
    logic [63:0]          c4_reg, c4_next;
    logic signed [31:0]   l5_reg, d5_reg, c5_reg, l5_next, d5_next, c5_next;
    logic signed [63:0]   m6_reg [6], m6_next [6];
    logic signed [63:0]   j7_reg [4], j7_next [4];
    logic signed [31:0]   j8_reg [4], j8_next [4];
    logic signed [63:0]   m9_reg [6], m9_next [6];
    logic [63:0]          qs10_reg, x10_reg, y10_reg, qs10_next, x10_next, y10_next;
    logic [31:0]          x11_reg, y11_reg, x11_next, y11_next;
    logic [63:0]          q11_reg, q11_next, q12_reg, q13_reg;
    logic [63:0]          xx12_reg, yy12_reg, xx12_next, yy12_next;
    logic [63:0]          n13_reg, n13_next;

    always_comb begin
        logic [63:0]       orv;
        logic [SH_W-1:0]   s;
        logic signed [63:0] cr;
        logic [63:0]       e, g;
        logic signed [63:0] f;
        int i;

        // stage 1: edge differences
        p1_next[0] = DW'(in_crd[2]) - DW'(in_crd[0]);
        p1_next[1] = DW'(in_crd[3]) - DW'(in_crd[1]);
        p1_next[2] = DW'(in_crd[4]) - DW'(in_crd[0]);
        p1_next[3] = DW'(in_crd[5]) - DW'(in_crd[1]);
        q1_next[0] = DW'(in_crd[8])  - DW'(in_crd[6]);
        q1_next[1] = DW'(in_crd[9])  - DW'(in_crd[7]);
        q1_next[2] = DW'(in_crd[10]) - DW'(in_crd[6]);
        q1_next[3] = DW'(in_crd[11]) - DW'(in_crd[7]);

        // stage 2: pre-shift into 32 bits
        orv = '0;
        for (i = 0; i < 4; i++) orv = orv | mag64(64'(q1_reg[i]));
        s = norm_shift(orv, SH_W'(31));
        for (i = 0; i < 4; i++) q2_next[i] = 32'(shr_sgn(64'(q1_reg[i]), s));
        orv = '0;
        for (i = 0; i < 4; i++) orv = orv | mag64(64'(p1_reg[i]));
        s = norm_shift(orv, SH_W'(31));
        for (i = 0; i < 4; i++) p2_next[i] = 32'(shr_sgn(64'(p1_reg[i]), s));

        // stage 3: UV edge products
        m3_next[0] = q2_reg[0] * q2_reg[0];
        m3_next[1] = q2_reg[1] * q2_reg[1];
        m3_next[2] = q2_reg[0] * q2_reg[2];
        m3_next[3] = q2_reg[1] * q2_reg[3];
        m3_next[4] = q2_reg[0] * q2_reg[3];
        m3_next[5] = q2_reg[1] * q2_reg[2];

        // stage 4: L, d, |cr|
        l4_next = m3_reg[0] + m3_reg[1];
        d4_next = m3_reg[2] + m3_reg[3];
        cr      = m3_reg[4] - m3_reg[5];
        c4_next = mag64(cr);
        deg_next = '0;
        deg_next[0] = 1'b0;
        for (i = 1; i < NST; i++) deg_next[i] = deg_reg[i-1];
        deg_next[3] = (l4_next == '0) || (cr == '0);

        // stage 5: common shift below 2^30
        orv = 64'(l4_reg) | mag64(d4_reg) | c4_reg;
        s = norm_shift(orv, SH_W'(30));
        l5_next = 32'(shr_sgn(l4_reg, s));
        d5_next = 32'(shr_sgn(d4_reg, s));
        c5_next = 32'(shr_sgn($signed(c4_reg), s));

        // stage 6: scaled Jacobian products
        m6_next[0] = p5_reg[0] * c5_reg;
        m6_next[1] = p5_reg[1] * c5_reg;
        m6_next[2] = l5_reg * p5_reg[2];
        m6_next[3] = d5_reg * p5_reg[0];
        m6_next[4] = l5_reg * p5_reg[3];
        m6_next[5] = d5_reg * p5_reg[1];

        // stage 7: Jacobian entries, zero map check
        j7_next[0] = m6_reg[0];
        j7_next[1] = m6_reg[1];
        j7_next[2] = m6_reg[2] - m6_reg[3];
        j7_next[3] = m6_reg[4] - m6_reg[5];
        deg_next[6] = deg_reg[5] ||
                      ((j7_next[0] == '0) && (j7_next[1] == '0) &&
                       (j7_next[2] == '0) && (j7_next[3] == '0));

        // stage 8: shift Jacobian below 2^30
        orv = '0;
        for (i = 0; i < 4; i++) orv = orv | mag64(j7_reg[i]);
        s = norm_shift(orv, SH_W'(30));
        for (i = 0; i < 4; i++) j8_next[i] = 32'(shr_sgn(j7_reg[i], s));

        // stage 9: fundamental form products
        m9_next[0] = j8_reg[0] * j8_reg[0];
        m9_next[1] = j8_reg[1] * j8_reg[1];
        m9_next[2] = j8_reg[2] * j8_reg[2];
        m9_next[3] = j8_reg[3] * j8_reg[3];
        m9_next[4] = j8_reg[0] * j8_reg[2];
        m9_next[5] = j8_reg[1] * j8_reg[3];

        // stage 10: E, G, F, E+G, |E-G|, 2|F|
        e = 64'(m9_reg[0] + m9_reg[1]);
        g = 64'(m9_reg[2] + m9_reg[3]);
        f = m9_reg[4] + m9_reg[5];
        qs10_next = e + g;
        x10_next  = (e >= g) ? (e - g) : (g - e);
        y10_next  = mag64(f) << 1;

        // stage 11: shift k so x, y fit 31 bits
        s = norm_shift(x10_reg | y10_reg, SH_W'(31));
        x11_next = 32'(x10_reg >> s);
        y11_next = 32'(y10_reg >> s);
        q11_next = qs10_reg >> s;

        // stage 12, 13: x^2 + y^2
        xx12_next = x11_reg * x11_reg;
        yy12_next = y11_reg * y11_reg;
        n13_next  = xx12_reg + yy12_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[NST-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            deg_reg  <= deg_next;
            p1_reg   <= p1_next;
            q1_reg   <= q1_next;
            p2_reg   <= p2_next;
            q2_reg   <= q2_next;
            p3_reg   <= p2_reg;
            p4_reg   <= p3_reg;
            p5_reg   <= p4_reg;
            m3_reg   <= m3_next;
            l4_reg   <= l4_next;
            d4_reg   <= d4_next;
            c4_reg   <= c4_next;
            l5_reg   <= l5_next;
            d5_reg   <= d5_next;
            c5_reg   <= c5_next;
            m6_reg   <= m6_next;
            j7_reg   <= j7_next;
            j8_reg   <= j8_next;
            m9_reg   <= m9_next;
            qs10_reg <= qs10_next;
            x10_reg  <= x10_next;
            y10_reg  <= y10_next;
            x11_reg  <= x11_next;
            y11_reg  <= y11_next;
            q11_reg  <= q11_next;
            xx12_reg <= xx12_next;
            yy12_reg <= yy12_next;
            q12_reg  <= q11_reg;
            n13_reg  <= n13_next;
            q13_reg  <= q12_reg;
        end
    end

    assign out_valid   = vld_reg[NST-1];
    assign out_mid.rad = n13_reg;
    assign out_mid.qk  = q13_reg;
    assign out_mid.deg = deg_reg[NST-1];

endmodule
`default_nettype wire

// ----- rtl/tma_sqrt.sv -----
`default_nettype none
module tma_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         en,
    input  wire logic                         in_valid,
    input  wire logic [tma_pkg::RAD_W-1:0]    in_rad,
    input  wire logic [SIDE_W-1:0]            in_side,
    output logic                              out_valid,
    output logic [tma_pkg::ROOT_W-1:0]        out_root,
    output logic [SIDE_W-1:0]                 out_side
);
    import tma_pkg::*;

    logic [SQ_STAGES-1:0] vld_reg;
    logic [RAD_W-1:0]     rad_reg  [SQ_STAGES], rad_next  [SQ_STAGES];
    logic [REM_W-1:0]     rem_reg  [SQ_STAGES], rem_next  [SQ_STAGES];
    logic [ROOT_W-1:0]    root_reg [SQ_STAGES], root_next [SQ_STAGES];
    logic [SIDE_W-1:0]    side_reg [SQ_STAGES];

    // Two result bits per stage, digit-by-digit floor root.
    always_comb begin
        logic [RAD_W-1:0]  rad;
        logic [REM_W-1:0]  rem, rt, trial;
        logic [ROOT_W-1:0] root;
        int st, j;
        for (st = 0; st < SQ_STAGES; st++) begin
            if (st == 0) begin
                rad  = in_rad;
                rem  = '0;
                root = '0;
            end else begin
                rad  = rad_reg[st-1];
                rem  = rem_reg[st-1];
                root = root_reg[st-1];
            end
            for (j = 0; j < STEPS; j++) begin
                rt    = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
                trial = {2'b00, root, 2'b01};
                if (rt >= trial) begin
                    rem  = rt - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    rem  = rt;
                    root = {root[ROOT_W-2:0], 1'b0};
                end
                rad = rad << 2;
            end
            rad_next[st]  = rad;
            rem_next[st]  = rem;
            root_next[st] = root;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[SQ_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg  <= rad_next;
            rem_reg  <= rem_next;
            root_reg <= root_next;
            side_reg[0] <= in_side;
            for (int st = 1; st < SQ_STAGES; st++) side_reg[st] <= side_reg[st-1];
        end
    end

    assign out_valid = vld_reg[SQ_STAGES-1];
    assign out_root  = root_reg[SQ_STAGES-1];
    assign out_side  = side_reg[SQ_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/tma_div.sv -----
`default_nettype none
module tma_div #(
    parameter int SIDE_W = 2
) (
    input  wire logic                        aclk,
    input  wire logic                        aresetn,
    input  wire logic                        en,
    input  wire logic                        in_valid,
    input  wire logic [tma_pkg::RAD_W-1:0]   in_num,
    input  wire logic [tma_pkg::RAD_W-1:0]   in_den,
    input  wire logic [SIDE_W-1:0]           in_side,
    output logic                             out_valid,
    output logic [tma_pkg::QUO_W-1:0]        out_quo,
    output logic [SIDE_W-1:0]                out_side
);
    import tma_pkg::*;

    logic [DIV_STAGES-1:0] vld_reg;
    logic [RAD_W-1:0]      rem_reg [DIV_STAGES], rem_next [DIV_STAGES];
    logic [RAD_W-1:0]      den_reg [DIV_STAGES], den_next [DIV_STAGES];
    logic [QUO_W-1:0]      quo_reg [DIV_STAGES], quo_next [DIV_STAGES];
    logic [SIDE_W-1:0]     side_reg [DIV_STAGES];

    // Restoring fraction divide, num <= den, two quotient bits per stage.
    always_comb begin
        logic [RAD_W-1:0] rem, den;
        logic [RAD_W:0]   t;
        logic [QUO_W-1:0] quo;
        int st, j;
        for (st = 0; st < DIV_STAGES; st++) begin
            if (st == 0) begin
                rem = in_num;
                den = in_den;
                quo = '0;
            end else begin
                rem = rem_reg[st-1];
                den = den_reg[st-1];
                quo = quo_reg[st-1];
            end
            for (j = 0; j < STEPS; j++) begin
                t = {rem, 1'b0};
                if (t >= {1'b0, den}) begin
                    rem = RAD_W'(t - {1'b0, den});
                    quo = {quo[QUO_W-2:0], 1'b1};
                end else begin
                    rem = t[RAD_W-1:0];
                    quo = {quo[QUO_W-2:0], 1'b0};
                end
            end
            rem_next[st] = rem;
            den_next[st] = den;
            quo_next[st] = quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= {vld_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            den_reg <= den_next;
            quo_reg <= quo_next;
            side_reg[0] <= in_side;
            for (int st = 1; st < DIV_STAGES; st++) side_reg[st] <= side_reg[st-1];
        end
    end

    assign out_valid = vld_reg[DIV_STAGES-1];
    assign out_quo   = quo_reg[DIV_STAGES-1];
    assign out_side  = side_reg[DIV_STAGES-1];

endmodule
`default_nettype wire

// ----- rtl/triangle_map_anisotropy.sv -----
`default_nettype none
// Triangle map anisotropy: one triangle per beat in, one eccentricity per beat
// out. A slave beat carries the three source vertices and the three UV vertices;
// the master beat carries the eccentricity of the stretch ellipse of the map
// (Q1.FRAC_BITS, 1<<FRAC_BITS = 1.0, floor rounded) and a degenerate flag
// that is set, with eccentricity 0, for a zero UV edge, zero UV height or an
// all-zero Jacobian. A new triangle is taken every cycle while s_tready is high.
// The pipe has 13 front-end stages, 16 + 16 stages for the two square roots at
// two bits a stage, 1 denominator stage, 31 divide stages at two quotient bits
// a stage and 1 output register. A two-entry output buffer keeps the pipe and the
// input moving while m_tready is low until a second result waits behind the
// held output beat; the whole pipe then holds, and s_tready returns in the cycle
// after the one in which m_tready takes the held beat.
module triangle_map_anisotropy #(
    parameter int FRAC_BITS   = 16,
    parameter int COORD_WIDTH = 24
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire logic                     s_tvalid,
    output logic                          s_tready,
    // from bit 0: src_ax, src_ay, src_bx, src_by, src_cx, src_cy,
    //             u_a, v_a, u_b, v_b, u_c, v_c (COORD_WIDTH each)
    input  wire logic [((12*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                          m_tvalid,
    input  wire logic                     m_tready,
    // from bit 0: eccentricity (FRAC_BITS+1 bits), zero fill
    output logic [((FRAC_BITS+8)/8)*8-1:0] m_tdata,
    // bit 0: degenerate
    output logic [0:0]                    m_tuser
);
    import tma_pkg::*;

    localparam int ECC_W = FRAC_BITS + 1;
    localparam int OUT_W = ((FRAC_BITS + 8) / 8) * 8;

    logic en;
    logic signed [COORD_WIDTH-1:0] crd [12];

    // front end
    logic fe_valid;
    mid_t fe_mid;

    // first root: h = floor(sqrt(x^2 + y^2))
    logic                 r1_valid;
    logic [ROOT_W-1:0]    r1_h;
    logic [RAD_W:0]       r1_side;

    // denominator stage
    logic                 dn_valid_reg;
    logic [RAD_W-1:0]     dn_num_reg, dn_den_reg, dn_num_next, dn_den_next;
    logic                 dn_eq_reg, dn_deg_reg, dn_eq_next, dn_deg_next;

    // divide and second root
    logic                 dv_valid;
    logic [QUO_W-1:0]     dv_quo;
    logic [1:0]           dv_side;
    logic [RAD_W-1:0]     r2_rad;
    logic                 r2_valid;
    logic [ROOT_W-1:0]    r2_root;
    logic [0:0]           r2_side;

    // output buffer
    logic                 fin_take;
    logic [ECC_W-1:0]     fin_ecc;
    logic                 out_valid_reg, out_valid_next;
    logic                 skid_valid_reg, skid_valid_next;
    logic [ECC_W-1:0]     out_ecc_reg, out_ecc_next, skid_ecc_reg, skid_ecc_next;
    logic                 out_deg_reg, out_deg_next, skid_deg_reg, skid_deg_next;

    // pipe advances unless the skid entry is occupied
    assign en       = !skid_valid_reg;
    assign s_tready = en;

    for (genvar i = 0; i < 12; i++) begin : g_unpack
        assign crd[i] = s_tdata[i*COORD_WIDTH +: COORD_WIDTH];
    end

    tma_front #(
        .COORD_WIDTH(COORD_WIDTH)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (s_tvalid),
        .in_crd   (crd),
        .out_valid(fe_valid),
        .out_mid  (fe_mid)
    );

    tma_sqrt #(
        .SIDE_W(RAD_W + 1)
    ) u_sqrt_h (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (fe_valid),
        .in_rad   (fe_mid.rad),
        .in_side  ({fe_mid.qk, fe_mid.deg}),
        .out_valid(r1_valid),
        .out_root (r1_h),
        .out_side (r1_side)
    );

    // den = (E+G)>>k + h, num = min(2h, den)
    always_comb begin
        logic [RAD_W-1:0] num;
        dn_den_next = r1_side[RAD_W:1] + RAD_W'(r1_h);
        num         = {(RAD_W-ROOT_W-1)'(0), r1_h, 1'b0};
        dn_num_next = (num > dn_den_next) ? dn_den_next : num;
        dn_eq_next  = (dn_num_next == dn_den_next);
        dn_deg_next = r1_side[0] || (dn_den_next == '0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dn_valid_reg <= 1'b0;
        end else if (en) begin
            dn_valid_reg <= r1_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dn_num_reg <= dn_num_next;
            dn_den_reg <= dn_den_next;
            dn_eq_reg  <= dn_eq_next;
            dn_deg_reg <= dn_deg_next;
        end
    end

    tma_div #(
        .SIDE_W(2)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dn_valid_reg),
        .in_num   (dn_num_reg),
        .in_den   (dn_den_reg),
        .in_side  ({dn_eq_reg, dn_deg_reg}),
        .out_valid(dv_valid),
        .out_quo  (dv_quo),
        .out_side (dv_side)
    );

    // e^2 in Q0.62; exactly one when num == den
    assign r2_rad = dv_side[1] ? (RAD_W'(1) << QUO_W)
                               : {(RAD_W-QUO_W)'(0), dv_quo};

    tma_sqrt #(
        .SIDE_W(1)
    ) u_sqrt_e (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (en),
        .in_valid (dv_valid),
        .in_rad   (r2_rad),
        .in_side  (dv_side[0]),
        .out_valid(r2_valid),
        .out_root (r2_root),
        .out_side (r2_side)
    );

    // root is Q1.31; keep the top FRAC_BITS+1 bits
    assign fin_take = en && r2_valid;
    assign fin_ecc  = r2_side[0] ? '0 : r2_root[ROOT_W-1 -: ECC_W];

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_ecc_next    = out_ecc_reg;
        out_deg_next    = out_deg_reg;
        skid_valid_next = skid_valid_reg;
        skid_ecc_next   = skid_ecc_reg;
        skid_deg_next   = skid_deg_reg;
        if (!out_valid_reg || m_tready) begin
            if (skid_valid_reg) begin
                out_valid_next  = 1'b1;
                out_ecc_next    = skid_ecc_reg;
                out_deg_next    = skid_deg_reg;
                skid_valid_next = 1'b0;
            end else begin
                out_valid_next = fin_take;
                if (fin_take) begin
                    out_ecc_next = fin_ecc;
                    out_deg_next = r2_side[0];
                end
            end
        end else if (fin_take) begin
            skid_valid_next = 1'b1;
            skid_ecc_next   = fin_ecc;
            skid_deg_next   = r2_side[0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_ecc_reg  <= out_ecc_next;
        out_deg_reg  <= out_deg_next;
        skid_ecc_reg <= skid_ecc_next;
        skid_deg_reg <= skid_deg_next;
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = OUT_W'(out_ecc_reg);
    assign m_tuser[0] = out_deg_reg;

endmodule
`default_nettype wire

// ----- bench/tb_triangle_map_anisotropy.sv -----
`default_nettype none
module tb_triangle_map_anisotropy;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC_BITS   = 16;
    localparam int COORD_WIDTH = 24;
    localparam int IN_W        = ((12*COORD_WIDTH+7)/8)*8;
    localparam int OUT_W       = ((FRAC_BITS+8)/8)*8;
    localparam int N_RAND      = 1700;
    localparam int IDLE_LIMIT  = 4000;   // cycles with no beat on either side
    localparam int CMAX        = 8388607;
    localparam int CMIN        = -8388608;
    localparam int ONE         = 65536;  // 1.0 in Q8.16

    typedef struct packed {
        logic [FRAC_BITS:0] ecc;
        logic               deg;
    } ecc_res_t;

    typedef struct {
        int       c[12];   // src_ax .. src_cy, u_a .. v_c
        bit       known;   // result typed in below
        ecc_res_t res;
    } tri_row_t;

    logic              aclk = 1'b0;
    logic              aresetn;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;
    logic [0:0]        m_tuser;

    triangle_map_anisotropy #(.FRAC_BITS(FRAC_BITS), .COORD_WIDTH(COORD_WIDTH)) uut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // stimulus list, and per-beat override of the predicted result
    logic [IN_W-1:0] tri_beats[$];
    bit              tri_known[$];
    ecc_res_t        tri_fixed[$];
    ecc_res_t        ecc_pending[$];   // expected eccentricity beats, oldest first

    int  n_sent = 0;       // triangles accepted on the slave side
    int  n_fail = 0;
    int  idle_cyc = 0;
    int  cyc = 0;
    bit  stim_ready = 0;

    // ---------------- predictor ----------------
    function automatic logic [63:0] mag(input logic signed [63:0] v);
        return v[63] ? 64'd0 - 64'(v) : 64'(v);
    endfunction

    // shift of magnitude, sign kept: truncates toward zero
    function automatic logic signed [63:0] shr_mag(input logic signed [63:0] v, input int s);
        logic [63:0] m;
        m = mag(v) >> s;
        return v[63] ? -$signed(m) : $signed(m);
    endfunction

    function automatic int bits_over(input logic [63:0] o, input int lim);
        int s;
        s = 0;
        while (s < 63 && (o >> s) >= (64'd1 << lim)) s++;
        return s;
    endfunction

    function automatic logic [63:0] root64(input logic [63:0] n);
        logic [63:0] res, b;
        res = 0;
        b = 64'd1 << 62;
        while (b > n) b >>= 2;
        while (b != 0) begin
            if (n >= res + b) begin
                n -= res + b;
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic ecc_res_t stretch_ecc(input logic [IN_W-1:0] beat);
        logic signed [63:0] c[12];
        logic signed [63:0] p[4], q[4], ldc[3], jac[4];
        logic signed [63:0] f;
        logic [63:0] o, lsq, e, g, qs, x, y, h, den, num, rem, r;
        ecc_res_t out;
        int s, i;
        out = '0;
        for (i = 0; i < 12; i++) c[i] = $signed(beat[i*COORD_WIDTH +: COORD_WIDTH]);
        p[0] = c[2] - c[0];  p[1] = c[3] - c[1];
        p[2] = c[4] - c[0];  p[3] = c[5] - c[1];
        q[0] = c[8] - c[6];  q[1] = c[9] - c[7];
        q[2] = c[10] - c[6]; q[3] = c[11] - c[7];
        o = mag(q[0]) | mag(q[1]) | mag(q[2]) | mag(q[3]);
        s = bits_over(o, 31);
        for (i = 0; i < 4; i++) q[i] = shr_mag(q[i], s);
        o = mag(p[0]) | mag(p[1]) | mag(p[2]) | mag(p[3]);
        s = bits_over(o, 31);
        for (i = 0; i < 4; i++) p[i] = shr_mag(p[i], s);
        // UV frame: edge length^2, dot and cross
        lsq = 64'(q[0]*q[0]) + 64'(q[1]*q[1]);
        ldc[0] = $signed(lsq);
        ldc[1] = q[0]*q[2] + q[1]*q[3];
        ldc[2] = q[0]*q[3] - q[1]*q[2];
        if (lsq == 0 || ldc[2] == 0) begin
            out.deg = 1'b1;
            return out;
        end
        ldc[2] = $signed(mag(ldc[2]));
        o = mag(ldc[0]) | mag(ldc[1]) | mag(ldc[2]);
        s = bits_over(o, 30);
        for (i = 0; i < 3; i++) ldc[i] = shr_mag(ldc[i], s);
        // Jacobian scaled by Xb^2*Yc
        jac[0] = p[0]*ldc[2];
        jac[1] = p[1]*ldc[2];
        jac[2] = ldc[0]*p[2] - ldc[1]*p[0];
        jac[3] = ldc[0]*p[3] - ldc[1]*p[1];
        if (jac[0] == 0 && jac[1] == 0 && jac[2] == 0 && jac[3] == 0) begin
            out.deg = 1'b1;
            return out;
        end
        o = mag(jac[0]) | mag(jac[1]) | mag(jac[2]) | mag(jac[3]);
        s = bits_over(o, 30);
        for (i = 0; i < 4; i++) jac[i] = shr_mag(jac[i], s);
        e = 64'(jac[0]*jac[0]) + 64'(jac[1]*jac[1]);
        g = 64'(jac[2]*jac[2]) + 64'(jac[3]*jac[3]);
        f = jac[0]*jac[2] + jac[1]*jac[3];
        qs = e + g;
        x = (e >= g) ? e - g : g - e;
        y = mag(f) << 1;
        s = bits_over(x | y, 31);
        x >>= s;
        y >>= s;
        h = root64(x*x + y*y);
        den = (qs >> s) + h;
        if (den == 0) begin
            out.deg = 1'b1;
            return out;
        end
        num = h << 1;
        if (num > den) num = den;
        // e^2 = 2h/(Q+h) in Q0.62, restoring division
        rem = num;
        r = 0;
        for (i = 0; i < 62; i++) begin
            rem <<= 1;
            r <<= 1;
            if (rem >= den) begin
                rem -= den;
                r |= 64'd1;
            end
        end
        if (num == den) r = 64'd1 << 62;
        out.ecc = (FRAC_BITS+1)'(root64(r) >> (31 - FRAC_BITS));
        return out;
    endfunction

    // ---------------- stimulus ----------------
    function automatic logic [IN_W-1:0] pack_tri(input int c[12]);
        logic [IN_W-1:0] b;
        b = '0;
        for (int i = 0; i < 12; i++) b[i*COORD_WIDTH +: COORD_WIDTH] = c[i][COORD_WIDTH-1:0];
        return b;
    endfunction

    function automatic int rnd_pm(input int lim);
        return int'($urandom_range(0, 2*lim)) - lim;
    endfunction

    function automatic int rnd_full();
        logic [COORD_WIDTH-1:0] v;
        v = COORD_WIDTH'($urandom);
        return int'($signed(v));
    endfunction

    // hand-picked triangles; results given only where obvious
    tri_row_t corner_rows[] = '{
        // everything at the origin: zero UV edge
        '{'{0,0,0,0,0,0, 0,0,0,0,0,0}, 1, '{0, 1'b1}},
        // identity map: circle, eccentricity 0
        '{'{0,0,ONE,0,0,ONE, 0,0,ONE,0,0,ONE}, 1, '{0, 1'b0}},
        // UV edge AB of zero length
        '{'{0,0,ONE,0,0,ONE, 7,7,7,7,ONE,ONE}, 1, '{0, 1'b1}},
        // collinear UV vertices: zero height
        '{'{0,0,ONE,0,0,ONE, 0,0,ONE,0,2*ONE,0}, 1, '{0, 1'b1}},
        // source collapsed to a point: zero Jacobian
        '{'{5,5,5,5,5,5, 0,0,ONE,0,0,ONE}, 1, '{0, 1'b1}},
        // plain 2x stretch in x
        '{'{0,0,2*ONE,0,0,ONE, 0,0,ONE,0,0,ONE}, 0, '{0, 1'b0}},
        // collinear source: collapsed map
        '{'{0,0,ONE,ONE,2*ONE,2*ONE, 0,0,ONE,0,0,ONE}, 0, '{0, 1'b0}},
        // coordinate extremes, identity map
        '{'{CMIN,CMIN,CMAX,CMIN,CMIN,CMAX, CMIN,CMIN,CMAX,CMIN,CMIN,CMAX}, 0, '{0, 1'b0}},
        // coordinate extremes, mixed signs
        '{'{CMIN,CMAX,CMAX,CMAX,CMIN,CMIN, CMAX,CMAX,CMIN,CMAX,CMAX,CMIN}, 0, '{0, 1'b0}},
        // thin UV sliver: cross product lost in the common shift, not flagged
        '{'{0,0,ONE,0,0,ONE, 0,0,4000000,3999999,3999999,3999998}, 0, '{0, 1'b0}},
        // all ones in every field
        '{'{-1,-1,-1,-1,-1,-1, -1,-1,-1,-1,-1,-1}, 1, '{0, 1'b1}},
        // tiny triangles, sides one LSB long
        '{'{0,0,1,0,0,1, CMAX,CMAX,CMAX-1,CMAX,CMAX,CMAX-1}, 0, '{0, 1'b0}}
    };

    task automatic add_tri(input int c[12], input bit known, input ecc_res_t res);
        tri_beats = {tri_beats, pack_tri(c)};
        tri_known = {tri_known, known};
        tri_fixed = {tri_fixed, res};
    endtask

    task automatic build_random();
        int c[12];
        int shape, t, sc;
        for (int n = 0; n < N_RAND; n++) begin
            shape = $urandom_range(0, 9);
            sc = 1 << $urandom_range(4, 20);
            for (int i = 0; i < 12; i += 2) begin
                // well-formed: each triangle near a base point
                if (i == 0 || i == 6) begin
                    c[i] = rnd_pm(1 << 22);
                    c[i+1] = rnd_pm(1 << 22);
                end else begin
                    c[i] = c[(i < 6) ? 0 : 6] + rnd_pm(sc);
                    c[i+1] = c[(i < 6) ? 1 : 7] + rnd_pm(sc);
                end
            end
            case (shape)
                0, 1: for (int i = 0; i < 12; i++) c[i] = rnd_full();
                6: begin            // UV C on line AB
                    t = rnd_pm(3);
                    c[10] = c[6] + t * (c[8] - c[6]);
                    c[11] = c[7] + t * (c[9] - c[7]);
                end
                7: begin            // source collinear or repeated point
                    t = rnd_pm(2);
                    c[4] = c[0] + t * (c[2] - c[0]);
                    c[5] = c[1] + t * (c[3] - c[1]);
                end
                8: begin            // UV A on B
                    c[8] = c[6];
                    c[9] = c[7];
                end
                9: for (int i = 6; i < 12; i++) c[i] = rnd_full();
                default: ;
            endcase
            add_tri(c, 1'b0, '0);
        end
    endtask

    // ---------------- checking ----------------
    task automatic report_mismatch(input string what, input int got, input int exp);
        $display("mismatch at %0t: %s got %0d expected %0d", $realtime, what, got, exp);
        n_fail++;
    endtask

    always @(posedge aclk) begin
        ecc_res_t want;
        cyc <= cyc + 1;
        if (aresetn) begin
            if (s_tvalid && s_tready) begin
                // predictor runs on accepted triangles without a table value; table value wins if given
                want = tri_known[n_sent] ? tri_fixed[n_sent] : stretch_ecc(s_tdata);
                ecc_pending = {ecc_pending, want};
                n_sent <= n_sent + 1;
            end
            if (m_tvalid && m_tready) begin
                if (ecc_pending.size() == 0) begin
                    report_mismatch("unexpected beat, eccentricity", m_tdata[FRAC_BITS:0], -1);
                end else begin
                    want = ecc_pending.pop_front();
                    if (m_tdata[FRAC_BITS:0] !== want.ecc)
                        report_mismatch("eccentricity", m_tdata[FRAC_BITS:0], want.ecc);
                    if (m_tuser[0] !== want.deg)
                        report_mismatch("degenerate", m_tuser[0], want.deg);
                end
            end
            // watchdog: nothing moved on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cyc <= 0;
            else idle_cyc <= idle_cyc + 1;
            if (idle_cyc >= IDLE_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ---------------- sender: bursts and gaps ----------------
    int burst_left = 0;
    int gap_left = 0;
    int shown = -1;          // index of the triangle on the bus

    always @(negedge aclk) begin
        if (aresetn && stim_ready) begin
            if (!(s_tvalid && n_sent == shown)) begin
                if (gap_left > 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (n_sent < tri_beats.size()) begin
                    s_tvalid <= 1'b1;
                    s_tdata <= tri_beats[n_sent];
                    shown <= n_sent;
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 40);
                        // one burst in four runs back to back
                        gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver: stall pattern ----------------
    logic [15:0] stall_pat = 16'hffff;
    int          rx_mode = 0;

    always @(negedge aclk) begin
        if (cyc % 300 == 0) begin
            rx_mode <= $urandom_range(0, 3);
            stall_pat <= 16'($urandom);
        end
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= stall_pat[cyc % 16];
            default: m_tready <= ($urandom_range(0, 9) < 2);
        endcase
    end

    // ---------------- run ----------------
    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        foreach (corner_rows[i]) add_tri(corner_rows[i].c, corner_rows[i].known,
                                         corner_rows[i].res);
        build_random();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        stim_ready = 1;
        wait (n_sent == tri_beats.size());
        wait (ecc_pending.size() == 0);
        repeat (200) @(posedge aclk);
        if (n_fail == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
`default_nettype wire
